>>> sv/dcpm_pkg.sv
package dcpm_pkg;

  localparam int CoefW = 32;
  localparam int OffW  = 48;
  localparam int ProdW = CoefW + 10;
  localparam int SumW  = ProdW + 2;
  localparam int VecW  = 61;

  localparam logic [1:0] STATUS_MAPPED  = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_OFF     = 2'd2;

  localparam logic [2:0] REG_M_ROW0_A_B      = 3'd0;
  localparam logic [2:0] REG_M_ROW0_C_ROW1_A = 3'd1;
  localparam logic [2:0] REG_M_ROW1_B_C      = 3'd2;
  localparam logic [2:0] REG_M_ROW2_A_B      = 3'd3;
  localparam logic [2:0] REG_M_ROW2_C        = 3'd4;
  localparam logic [2:0] REG_OFFSET_X        = 3'd5;
  localparam logic [2:0] REG_OFFSET_Y        = 3'd6;
  localparam logic [2:0] REG_OFFSET_Z        = 3'd7;

  typedef struct packed {
    logic [CoefW-1:0] m00;
    logic [CoefW-1:0] m01;
    logic [CoefW-1:0] m02;
    logic [CoefW-1:0] m10;
    logic [CoefW-1:0] m11;
    logic [CoefW-1:0] m12;
    logic [CoefW-1:0] m20;
    logic [CoefW-1:0] m21;
    logic [CoefW-1:0] m22;
    logic [OffW-1:0]  tx;
    logic [OffW-1:0]  ty;
    logic [OffW-1:0]  tz;
  } coef_t;

  typedef struct packed {
    logic        invalid;
    logic [17:0] didx;
  } meta_t;

endpackage

>>> sv/dcpm_cfg.sv
module dcpm_cfg #(
  parameter int FRACTION_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output dcpm_pkg::coef_t      coef
);

  logic [63:0] r0, r1, r2, r3;
  logic [31:0] r4;
  logic [47:0] r5, r6, r7;
  logic        wr;
  logic [2:0]  idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      r0 <= '0;
      r1 <= '0;
      r2 <= '0;
      r3 <= '0;
      r4 <= 32'(64'd1 << FRACTION_BITS);
      r5 <= '0;
      r6 <= '0;
      r7 <= '0;
    end else if (wr) begin
      case (idx)
        dcpm_pkg::REG_M_ROW0_A_B:      r0 <= pwdata;
        dcpm_pkg::REG_M_ROW0_C_ROW1_A: r1 <= pwdata;
        dcpm_pkg::REG_M_ROW1_B_C:      r2 <= pwdata;
        dcpm_pkg::REG_M_ROW2_A_B:      r3 <= pwdata;
        dcpm_pkg::REG_M_ROW2_C:        r4 <= pwdata[31:0];
        dcpm_pkg::REG_OFFSET_X:        r5 <= pwdata[47:0];
        dcpm_pkg::REG_OFFSET_Y:        r6 <= pwdata[47:0];
        dcpm_pkg::REG_OFFSET_Z:        r7 <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dcpm_pkg::REG_M_ROW0_A_B:      prdata = r0;
      dcpm_pkg::REG_M_ROW0_C_ROW1_A: prdata = r1;
      dcpm_pkg::REG_M_ROW1_B_C:      prdata = r2;
      dcpm_pkg::REG_M_ROW2_A_B:      prdata = r3;
      dcpm_pkg::REG_M_ROW2_C:        prdata = {32'd0, r4};
      dcpm_pkg::REG_OFFSET_X:        prdata = {16'd0, r5};
      dcpm_pkg::REG_OFFSET_Y:        prdata = {16'd0, r6};
      dcpm_pkg::REG_OFFSET_Z:        prdata = {16'd0, r7};
      default:                       prdata = '0;
    endcase
  end

  assign coef = '{m00: r0[31:0], m01: r0[63:32], m02: r1[31:0],
                  m10: r1[63:32], m11: r2[31:0], m12: r2[63:32],
                  m20: r3[31:0], m21: r3[63:32], m22: r4,
                  tx: r5, ty: r6, tz: r7};

endmodule

>>> sv/dcpm_proj.sv
module dcpm_proj #(
  parameter int DEPTH_WIDTH = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [8:0]                           col,
  input  logic [8:0]                           row,
  input  logic [15:0]                          d,
  input  dcpm_pkg::coef_t                      coef,
  output logic                                 valid,
  output dcpm_pkg::meta_t                      meta,
  output logic signed [dcpm_pkg::VecW-1:0]     vx,
  output logic signed [dcpm_pkg::VecW-1:0]     vy,
  output logic signed [dcpm_pkg::VecW-1:0]     vz
);

  localparam int PW = dcpm_pkg::ProdW;
  localparam int SW = dcpm_pkg::SumW;
  localparam int VW = dcpm_pkg::VecW;

  logic signed [9:0]    scol, srow;
  logic                 v1, v2, v3;
  dcpm_pkg::meta_t      m1, m2, m3;
  logic [15:0]          d1, d2;
  logic signed [PW-1:0] pxc, pxr, pyc, pyr, pzc, pzr;
  logic signed [SW-1:0] sx, sy, sz;
  logic signed [VW-1:0] mx, my, mz;

  assign scol = $signed({1'b0, col});
  assign srow = $signed({1'b0, row});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxc <= PW'($signed(coef.m00)) * PW'(scol);
      pxr <= PW'($signed(coef.m01)) * PW'(srow);
      pyc <= PW'($signed(coef.m10)) * PW'(scol);
      pyr <= PW'($signed(coef.m11)) * PW'(srow);
      pzc <= PW'($signed(coef.m20)) * PW'(scol);
      pzr <= PW'($signed(coef.m21)) * PW'(srow);
      d1  <= d;
      m1  <= '{invalid: (d == 16'd0) || (d == 16'hFFFF),
               didx: 18'(21'(row) * 21'(DEPTH_WIDTH) + 21'(col))};

      sx <= SW'(pxc) + SW'(pxr) + SW'($signed(coef.m02));
      sy <= SW'(pyc) + SW'(pyr) + SW'($signed(coef.m12));
      sz <= SW'(pzc) + SW'(pzr) + SW'($signed(coef.m22));
      d2 <= d1;
      m2 <= m1;

      mx <= VW'(sx) * VW'($signed({1'b0, d2}));
      my <= VW'(sy) * VW'($signed({1'b0, d2}));
      mz <= VW'(sz) * VW'($signed({1'b0, d2}));
      m3 <= m2;

      vx   <= mx + VW'($signed(coef.tx));
      vy   <= my + VW'($signed(coef.ty));
      vz   <= mz + VW'($signed(coef.tz));
      meta <= m3;
    end
  end

endmodule

>>> sv/dcpm_div.sv
module dcpm_div #(
  parameter int QW = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  dcpm_pkg::meta_t                  meta,
  input  logic signed [dcpm_pkg::VecW-1:0] vx,
  input  logic signed [dcpm_pkg::VecW-1:0] vy,
  input  logic signed [dcpm_pkg::VecW-1:0] vz,
  output logic                             valid,
  output logic [1:0]                       status,
  output logic [17:0]                      didx,
  output logic [QW-1:0]                    qx,
  output logic [QW-1:0]                    qy
);

  localparam int VW = dcpm_pkg::VecW;
  localparam int RW = VW + QW;

  logic          zpos, negx, negy, badx, bady;
  logic [VW-1:0] magx, magy, den0;
  logic [RW-1:0] lim;

  logic          vld  [0:QW];
  logic [1:0]    stat [0:QW];
  logic [17:0]   dix  [0:QW];
  logic [VW-1:0] den  [0:QW];
  logic [VW-1:0] remx [0:QW];
  logic [VW-1:0] remy [0:QW];
  logic [QW-1:0] quox [0:QW];
  logic [QW-1:0] quoy [0:QW];

  assign zpos = !vz[VW-1] && (vz != '0);
  assign negx = vx[VW-1];
  assign negy = vy[VW-1];
  assign magx = negx ? VW'(-vx) : VW'(vx);
  assign magy = negy ? VW'(-vy) : VW'(vy);
  assign den0 = VW'(vz);
  assign lim  = RW'(den0) << QW;
  assign badx = negx ? (magx >= den0) : (RW'(magx) >= lim);
  assign bady = negy ? (magy >= den0) : (RW'(magy) >= lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (meta.invalid) begin
        stat[0] <= dcpm_pkg::STATUS_INVALID;
      end else if (!zpos || badx || bady) begin
        stat[0] <= dcpm_pkg::STATUS_OFF;
      end else begin
        stat[0] <= dcpm_pkg::STATUS_MAPPED;
      end
      dix[0]  <= meta.didx;
      den[0]  <= den0;
      remx[0] <= negx ? '0 : magx;
      remy[0] <= negy ? '0 : magy;
      quox[0] <= '0;
      quoy[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [RW-1:0] sh;
    logic          fitx, fity;

    assign sh   = RW'(den[k]) << B;
    assign fitx = RW'(remx[k]) >= sh;
    assign fity = RW'(remy[k]) >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stat[k+1] <= stat[k];
        dix[k+1]  <= dix[k];
        den[k+1]  <= den[k];
        remx[k+1] <= fitx ? VW'(RW'(remx[k]) - sh) : remx[k];
        remy[k+1] <= fity ? VW'(RW'(remy[k]) - sh) : remy[k];
        quox[k+1] <= quox[k] | (fitx ? (QW'(1) << B) : '0);
        quoy[k+1] <= quoy[k] | (fity ? (QW'(1) << B) : '0);
      end
    end
  end

  assign valid  = vld[QW];
  assign status = stat[QW];
  assign didx   = dix[QW];
  assign qx     = quox[QW];
  assign qy     = quoy[QW];

endmodule

>>> sv/depth_to_color_pixel_map_top.sv
// channel | direction | handshake           | word
// pixel   | in        | in_valid / in_ready   | pixel_col, pixel_row, depth_mm
// result  | out       | out_valid / out_ready | status, color_x, color_y,
//         |           |                       | color_address, depth_index
// config  | in        | psel/penable/pwrite   | paddr, pwdata, prdata
// One word per cycle unless the output stalls. A word passes four projection
// stages, a divider entry stage, Q divider stages (one quotient bit each) and
// the output register, with Q = clog2(max(COLOR_WIDTH, COLOR_HEIGHT)).
// Synchronous reset clears all valid bits; configuration registers take their reset values.
// A stall on the output freezes the whole pipeline; in_ready follows it.
module depth_to_color_pixel_map_top #(
  parameter int COLOR_WIDTH   = 1920,
  parameter int COLOR_HEIGHT  = 1080,
  parameter int DEPTH_WIDTH   = 512,
  parameter int FRACTION_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  pixel_col,
  input  logic [8:0]  pixel_row,
  input  logic [15:0] depth_mm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [10:0] color_x,
  output logic [10:0] color_y,
  output logic [20:0] color_address,
  output logic [17:0] depth_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int MaxDim = (COLOR_WIDTH > COLOR_HEIGHT) ? COLOR_WIDTH : COLOR_HEIGHT;
  localparam int QW     = $clog2(MaxDim);
  localparam int AW     = 2 * QW + 2;

  logic                             en;
  dcpm_pkg::coef_t                  coef;
  logic                             pv;
  dcpm_pkg::meta_t                  pmeta;
  logic signed [dcpm_pkg::VecW-1:0] vx, vy, vz;
  logic                             dv;
  logic [1:0]                       dstat;
  logic [17:0]                      ddix;
  logic [QW-1:0]                    qx, qy;
  logic                             mapped;

  assign pready   = 1'b1;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  dcpm_cfg #(.FRACTION_BITS(FRACTION_BITS)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .coef
  );

  dcpm_proj #(.DEPTH_WIDTH(DEPTH_WIDTH)) u_proj (
    .clk, .rst, .en, .in_valid,
    .col(pixel_col), .row(pixel_row), .d(depth_mm), .coef,
    .valid(pv), .meta(pmeta), .vx, .vy, .vz
  );

  dcpm_div #(.QW(QW)) u_div (
    .clk, .rst, .en, .in_valid(pv), .meta(pmeta), .vx, .vy, .vz,
    .valid(dv), .status(dstat), .didx(ddix), .qx, .qy
  );

  assign mapped = (dstat == dcpm_pkg::STATUS_MAPPED)
                  && ({1'b0, qx} < (QW + 1)'(COLOR_WIDTH))
                  && ({1'b0, qy} < (QW + 1)'(COLOR_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth_index <= ddix;
      if (mapped) begin
        status        <= dcpm_pkg::STATUS_MAPPED;
        color_x       <= 11'(qx);
        color_y       <= 11'(qy);
        color_address <= 21'(AW'(qy) * AW'(COLOR_WIDTH) + AW'(qx));
      end else begin
        status        <= (dstat == dcpm_pkg::STATUS_MAPPED) ? dcpm_pkg::STATUS_OFF : dstat;
        color_x       <= '0;
        color_y       <= '0;
        color_address <= '0;
      end
    end
  end

endmodule

>>> sv/dcpm_checker.sv
module dcpm_checker #(
  parameter int COLOR_WIDTH  = 1920,
  parameter int COLOR_HEIGHT = 1080
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [10:0] color_x,
  input logic [10:0] color_y,
  input logic [20:0] color_address
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(color_address))
    else $error("result word changed while stalled");

  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dcpm_pkg::STATUS_MAPPED
      |-> color_x == 11'd0 && color_y == 11'd0 && color_address == 21'd0)
    else $error("coordinates not cleared for unmapped pixel");

  a_in_image: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dcpm_pkg::STATUS_MAPPED
      |-> 32'(color_x) < COLOR_WIDTH && 32'(color_y) < COLOR_HEIGHT)
    else $error("mapped pixel outside colour image");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == dcpm_pkg::STATUS_MAPPED || status == dcpm_pkg::STATUS_INVALID
                  || status == dcpm_pkg::STATUS_OFF)
    else $error("bad status code");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind depth_to_color_pixel_map_top dcpm_checker #(
  .COLOR_WIDTH(COLOR_WIDTH), .COLOR_HEIGHT(COLOR_HEIGHT)
) u_chk (.*);

>>> tb/depth_to_color_pixel_map_top_test.sv
module depth_to_color_pixel_map_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 1920;
  localparam int CH = 1080;
  localparam int DW = 512;
  localparam int LATENCY = 5 + 11;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] cx;
    logic [10:0] cy;
    logic [20:0] addr;
    logic [17:0] didx;
  } pix_res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [8:0] pixel_col = 0;
  logic [8:0] pixel_row = 0;
  logic [15:0] depth_mm = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [10:0] color_x, color_y;
  logic [20:0] color_address;
  logic [17:0] depth_index;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = 0;
  logic [63:0] pwdata = 0;
  logic [63:0] prdata;
  logic pready;

  depth_to_color_pixel_map_top dut (.*);

  always #10 clk = ~clk;

  logic [63:0] regs [8];
  pix_res_t mapped_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_out = 0;
  bit pause_out = 0;

  function automatic longint sx(logic [63:0] v, int w);
    logic [63:0] m;
    m = v << (64 - w);
    return $signed(m) >>> (64 - w);
  endfunction

  function automatic pix_res_t map_pixel(logic [8:0] c, logic [8:0] r, logic [15:0] d);
    pix_res_t p;
    longint vx, vy, vz, qx, qy, lc, lr, ld;
    p = '0;
    lc = c; lr = r; ld = d;
    p.didx = 18'((lr * DW + lc));
    if (d == 0 || d == 16'hFFFF) begin
      p.status = dcpm_pkg::STATUS_INVALID;
      return p;
    end
    vx = ld * (sx(regs[0], 32) * lc + sx(regs[0] >> 32, 32) * lr + sx(regs[1], 32))
         + sx(regs[5], 48);
    vy = ld * (sx(regs[1] >> 32, 32) * lc + sx(regs[2], 32) * lr + sx(regs[2] >> 32, 32))
         + sx(regs[6], 48);
    vz = ld * (sx(regs[3], 32) * lc + sx(regs[3] >> 32, 32) * lr + sx(regs[4], 32))
         + sx(regs[7], 48);
    if (vz <= 0) begin
      p.status = dcpm_pkg::STATUS_OFF;
      return p;
    end
    qx = vx / vz;
    qy = vy / vz;
    if (qx >= 0 && qx < CW && qy >= 0 && qy < CH) begin
      p.status = dcpm_pkg::STATUS_MAPPED;
      p.cx = 11'(qx);
      p.cy = 11'(qy);
      p.addr = 21'(qy * CW + qx);
    end else begin
      p.status = dcpm_pkg::STATUS_OFF;
    end
    return p;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      dcpm_pkg::REG_M_ROW2_C: regs[idx] = v & 64'hFFFF_FFFF;
      dcpm_pkg::REG_OFFSET_X, dcpm_pkg::REG_OFFSET_Y,
      dcpm_pkg::REG_OFFSET_Z: regs[idx] = v & 64'hFFFF_FFFF_FFFF;
      default: regs[idx] = v;
    endcase
  endtask

  task automatic send_pixel(logic [8:0] c, logic [8:0] r, logic [15:0] d, bit gaps = 1);
    int g;
    g = 0;
    if (gaps) begin
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
          ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    end
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; pixel_col <= c; pixel_row <= r; depth_mm <= d;
    mapped_q.push_back(map_pixel(c, r, d));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] pair(int lo, int hi);
    return {32'(hi), 32'(lo)};
  endfunction

  // q20 matrix that roughly maps depth pixels onto the colour frame
  task automatic load_camera();
    write_reg(dcpm_pkg::REG_M_ROW0_A_B, pair(3 << 20, 0));
    write_reg(dcpm_pkg::REG_M_ROW0_C_ROW1_A, pair(100 << 20, 0));
    write_reg(dcpm_pkg::REG_M_ROW1_B_C, pair(5 << 19, 50 << 20));
    write_reg(dcpm_pkg::REG_M_ROW2_A_B, pair(0, 0));
    write_reg(dcpm_pkg::REG_M_ROW2_C, 64'(1 << 20));
    write_reg(dcpm_pkg::REG_OFFSET_X, 64'($signed(-48'sd5000 <<< 20)));
    write_reg(dcpm_pkg::REG_OFFSET_Y, 64'(48'sd3000 <<< 20));
    write_reg(dcpm_pkg::REG_OFFSET_Z, 64'(48'sd100 <<< 20));
  endtask

  function automatic logic [15:0] rand_depth();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 20));
      default: return 16'($urandom_range(1, 65534));
    endcase
  endfunction

  task automatic test_defaults();
    send_pixel(0, 0, 1);
    send_pixel(5, 7, 100);
    drain();
  endtask

  task automatic test_directed();
    load_camera();
    send_pixel(0, 0, 0);
    send_pixel(511, 423, 16'hFFFF);
    send_pixel(511, 511, 1);
    send_pixel(0, 0, 65534);
    send_pixel(511, 511, 65534);
    send_pixel(300, 200, 1000);
    send_pixel(100, 100, 1);
    send_pixel(256, 256, 32768);
    send_pixel(1, 1, 2);
    drain();
    // negative z everywhere
    write_reg(dcpm_pkg::REG_M_ROW2_C, 64'h8000_0000);
    write_reg(dcpm_pkg::REG_OFFSET_Z, 64'h8000_0000_0000);
    send_pixel(10, 10, 500);
    send_pixel(0, 0, 65534);
    drain();
    // zero z
    write_reg(dcpm_pkg::REG_M_ROW2_C, 64'd0);
    write_reg(dcpm_pkg::REG_OFFSET_Z, 64'd0);
    send_pixel(3, 4, 77);
    drain();
    // extreme coefficients
    write_reg(dcpm_pkg::REG_M_ROW0_A_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(dcpm_pkg::REG_M_ROW0_C_ROW1_A, 64'h7FFF_FFFF_8000_0000);
    write_reg(dcpm_pkg::REG_M_ROW1_B_C, 64'h8000_0000_7FFF_FFFF);
    write_reg(dcpm_pkg::REG_M_ROW2_A_B, 64'h0000_0001_0000_0001);
    write_reg(dcpm_pkg::REG_M_ROW2_C, 64'h7FFF_FFFF);
    write_reg(dcpm_pkg::REG_OFFSET_X, 64'h7FFF_FFFF_FFFF);
    write_reg(dcpm_pkg::REG_OFFSET_Y, 64'h8000_0000_0000);
    write_reg(dcpm_pkg::REG_OFFSET_Z, 64'h7FFF_FFFF_FFFF);
    send_pixel(511, 511, 65534);
    send_pixel(0, 0, 1);
    send_pixel(200, 300, 4000);
    drain();
  endtask

  task automatic test_random_camera(int n);
    load_camera();
    repeat (n) send_pixel(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                          rand_depth());
    drain();
  endtask

  task automatic test_random_regs(int n);
    for (int i = 0; i < 8; i++)
      write_reg(3'(i), {$urandom, $urandom} >> ($urandom_range(0, 1) * 24));
    // keep z mostly positive so divisions happen
    write_reg(dcpm_pkg::REG_M_ROW2_A_B,
              pair($urandom_range(0, 1 << 12), $urandom_range(0, 1 << 12)));
    write_reg(dcpm_pkg::REG_OFFSET_Z, 64'($urandom_range(0, 1 << 30)));
    repeat (n) send_pixel(9'($urandom), 9'($urandom), rand_depth());
    drain();
  endtask

  task automatic test_backpressure();
    load_camera();
    hold_out = 1;
    repeat (60) send_pixel(9'($urandom), 9'($urandom_range(0, 423)), rand_depth(), 0);
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (hold_out || pause_out) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 29) == 0) ? 0 : ($urandom_range(0, 3) != 0);
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        n = 0;
        while (n < 150) begin
          @(posedge clk);
          n++;
        end
        hold_out = 0;
      end else if (!rst && $urandom_range(0, 199) == 0) begin
        pause_out = 1;
        repeat ($urandom_range(8, 40)) @(posedge clk);
        pause_out = 0;
      end
    end
  end

  always @(posedge clk) begin
    pix_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (mapped_q.size() == 0) begin
        $display("%0t unexpected word: status %0d", $time, status);
        errors++;
      end else begin
        e = mapped_q.pop_front();
        if (status !== e.status) begin
          $display("%0t status exp %0d got %0d", $time, e.status, status); errors++;
        end
        if (color_x !== e.cx) begin
          $display("%0t color_x exp %0d got %0d", $time, e.cx, color_x); errors++;
        end
        if (color_y !== e.cy) begin
          $display("%0t color_y exp %0d got %0d", $time, e.cy, color_y); errors++;
        end
        if (color_address !== e.addr) begin
          $display("%0t color_address exp %0d got %0d", $time, e.addr, color_address);
          errors++;
        end
        if (depth_index !== e.didx) begin
          $display("%0t depth_index exp %0d got %0d", $time, e.didx, depth_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) regs[i] = 0;
    regs[4] = 1 << 20;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_defaults();
    test_directed();
    test_backpressure();
    test_random_camera(500);
    for (int k = 0; k < 5; k++) test_random_regs(100);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
